>>> rtl/bvm_pkg.sv
// ----------------------------------------------------------------------------
// bvm_pkg
// Shared types and constants for the DC bus voltage monitor: converter
// lookup table, register indices and reset values, controller interface.
// ----------------------------------------------------------------------------
`default_nettype none

package bvm_pkg;

   // Lookup table: converter word break points and the volts at each
   localparam int TABLE_POINTS = 43;
   localparam int IDX_W        = $clog2(TABLE_POINTS);
   localparam int ADC_W        = 16;
   localparam int VOLT_W       = 9;
   localparam int PROD_W       = ADC_W + VOLT_W;
   localparam int DIV_STEPS    = VOLT_W;
   localparam int STEP_W       = $clog2(DIV_STEPS);

   localparam logic [ADC_W-1:0] ADC_POINTS [0:TABLE_POINTS-1] = '{
      16'd733,   16'd1466,  16'd2200,  16'd2933,  16'd3666,  16'd4399,
      16'd5133,  16'd5866,  16'd6599,  16'd7332,  16'd8066,  16'd8799,
      16'd9532,  16'd10265, 16'd10999, 16'd11732, 16'd12465, 16'd13198,
      16'd13932, 16'd14665, 16'd15398, 16'd16131, 16'd16864, 16'd17598,
      16'd18331, 16'd19064, 16'd19797, 16'd20531, 16'd21264, 16'd21997,
      16'd22730, 16'd23464, 16'd24197, 16'd24930, 16'd25663, 16'd26397,
      16'd27130, 16'd27863, 16'd28596, 16'd29329, 16'd30063, 16'd30796,
      16'd31529
   };

   localparam logic [VOLT_W-1:0] VOLT_POINTS [0:TABLE_POINTS-1] = '{
      9'd10,  9'd20,  9'd30,  9'd40,  9'd50,  9'd60,  9'd70,  9'd80,
      9'd90,  9'd100, 9'd110, 9'd120, 9'd130, 9'd140, 9'd150, 9'd160,
      9'd170, 9'd180, 9'd190, 9'd200, 9'd210, 9'd220, 9'd230, 9'd240,
      9'd250, 9'd260, 9'd270, 9'd280, 9'd290, 9'd300, 9'd310, 9'd320,
      9'd330, 9'd340, 9'd350, 9'd360, 9'd370, 9'd380, 9'd390, 9'd400,
      9'd410, 9'd420, 9'd430
   };

   // Averaging ring
   localparam int AVG_DEPTH = 8;
   localparam int AVG_SHIFT = 3;
   localparam int SUM_W     = VOLT_W + AVG_SHIFT;

   // Register file
   localparam int CNT_W      = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OVERVOLT_LIMIT    = 3'd0,
      CSR_UNDERVOLT_LIMIT   = 3'd1,
      CSR_UNDERVOLT_ENABLE  = 3'd2,
      CSR_PRECHARGE_LOW     = 3'd3,
      CSR_PRECHARGE_HIGH    = 3'd4,
      CSR_PRECHARGE_RELEASE = 3'd5,
      CSR_SETTLE_COUNT      = 3'd6
   } csr_index_type;

   localparam logic [VOLT_W-1:0] RST_OVERVOLT_LIMIT    = 9'd400;
   localparam logic [VOLT_W-1:0] RST_UNDERVOLT_LIMIT   = 9'd150;
   localparam logic              RST_UNDERVOLT_ENABLE  = 1'b1;
   localparam logic [VOLT_W-1:0] RST_PRECHARGE_LOW     = 9'd200;
   localparam logic [VOLT_W-1:0] RST_PRECHARGE_HIGH    = 9'd420;
   localparam logic [VOLT_W-1:0] RST_PRECHARGE_RELEASE = 9'd150;
   localparam logic [CNT_W-1:0]  RST_SETTLE_COUNT      = 10'd100;

   // Controller
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MULT,
      ST_DIVIDE,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load;     // take the sample, set up clamp or search
      logic step;     // advance the table index
      logic mult;     // form interpolation product and span
      logic div;      // one restoring divide step
      logic commit;   // update ring, flags and result register
   } cmd_type;

   typedef struct packed {
      logic clamped;  // sample is at or beyond a table end
      logic hit;      // sample lies below the next break point
      logic div_last; // current divide step is the final one
   } status_type;

endpackage

`default_nettype wire

>>> rtl/bus_voltage_monitor_precharge.sv
// ----------------------------------------------------------------------------
// bus_voltage_monitor_precharge
// DC bus voltage monitor with over/under-voltage faults and precharge
// supervision.
// ----------------------------------------------------------------------------
// Each accepted item is one raw converter word. It is turned into volts
// through a 43-point table (clamped at both ends, truncating linear
// interpolation between points), pushed into an 8-entry ring whose mean is
// the filtered voltage, and checked against the fault limits and the
// precharge window. One result item per input item. The conversion time is
// set by the table scan, one break point compared per cycle up to the table
// interval the word falls in (0..41), then a multiply step and a 9-step
// restoring divide; a word at or beyond a table end skips all three and
// goes straight to commit. A new item is taken only once the previous one
// has been committed; a result that is not yet collected blocks the next
// commit but not the next accept. Fault flags are sticky until reset.
// Register writes go through the csr_ port; the user must write only while
// the block is idle, which it does not enforce; unknown indices are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module bus_voltage_monitor_precharge (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // register port
   input  wire logic                           csr_wr_en,
   input  wire logic [bvm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bvm_pkg::CSR_DATA_W-1:0] csr_wdata,
   // sample in
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [bvm_pkg::ADC_W-1:0]      req_adc_sample,
   // result out
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [bvm_pkg::VOLT_W-1:0]          rsp_bus_volt,
   output logic [bvm_pkg::VOLT_W-1:0]          rsp_bus_volt_avg,
   output logic                                rsp_over_volt,
   output logic                                rsp_under_volt,
   output logic                                rsp_precharge_ready,
   output logic                                rsp_relay_closed,
   output logic                                rsp_pwm_shutdown
);
   import bvm_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer: handshakes and step ordering
   bvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Conversion, ring, flags, registers and result register
   bvm_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_adc_sample      (req_adc_sample),
      .cmd                 (cmd),
      .status              (status),
      .rsp_bus_volt        (rsp_bus_volt),
      .rsp_bus_volt_avg    (rsp_bus_volt_avg),
      .rsp_over_volt       (rsp_over_volt),
      .rsp_under_volt      (rsp_under_volt),
      .rsp_precharge_ready (rsp_precharge_ready),
      .rsp_relay_closed    (rsp_relay_closed),
      .rsp_pwm_shutdown    (rsp_pwm_shutdown)
   );

endmodule

`default_nettype wire

>>> rtl/bvm_ctrl.sv
// ----------------------------------------------------------------------------
// bvm_ctrl
// Sequencer: table search, multiply, serial divide, commit; owns the
// handshake on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module bvm_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output bvm_pkg::cmd_type         cmd,
   input  wire bvm_pkg::status_type status
);
   import bvm_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (status.clamped)  state_in = ST_COMMIT;
            else if (status.hit) state_in = ST_MULT;
         end
         ST_MULT: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SEARCH: begin
            cmd.step = !status.clamped && !status.hit;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
         end
         ST_DIVIDE: begin
            cmd.div = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit)     rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/bvm_datapath.sv
// ----------------------------------------------------------------------------
// bvm_datapath
// Conversion datapath, averaging ring, fault and precharge flags, register
// file and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bvm_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [bvm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [bvm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic [bvm_pkg::ADC_W-1:0]           req_adc_sample,
   input  wire bvm_pkg::cmd_type                    cmd,
   output bvm_pkg::status_type                      status,
   output logic [bvm_pkg::VOLT_W-1:0]               rsp_bus_volt,
   output logic [bvm_pkg::VOLT_W-1:0]               rsp_bus_volt_avg,
   output logic                                     rsp_over_volt,
   output logic                                     rsp_under_volt,
   output logic                                     rsp_precharge_ready,
   output logic                                     rsp_relay_closed,
   output logic                                     rsp_pwm_shutdown
);
   import bvm_pkg::*;

   // Registers
   logic [VOLT_W-1:0] ov_limit_ff, uv_limit_ff, pc_low_ff, pc_high_ff, pc_rel_ff;
   logic              uv_en_ff;
   logic [CNT_W-1:0]  settle_ff;

   // Conversion
   logic [ADC_W-1:0]  raw_ff;
   logic              clamped_ff;
   logic [IDX_W-1:0]  k_ff, kn;
   logic [PROD_W-1:0] rem_ff, rem_in, shifted;
   logic [ADC_W-1:0]  span_ff;
   logic [VOLT_W-1:0] quot_ff, quot_in;
   logic [STEP_W-1:0] bit_ff;
   logic [VOLT_W-1:0] volts_ff, volts_in;
   logic              ge;

   // Ring and supervision state
   logic [VOLT_W-1:0] hist_ff [AVG_DEPTH];
   logic [AVG_SHIFT-1:0] ptr_ff;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [VOLT_W-1:0] avg;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              over_ff, under_ff, ready_ff, relay_ff;
   logic              over_in, under_in, ready_in, relay_in;
   logic              ov_hit, uv_hit, in_window;

   assign kn = k_ff + IDX_W'(1);

   assign status.clamped  = clamped_ff;
   assign status.hit      = raw_ff < ADC_POINTS[kn];
   assign status.div_last = bit_ff == '0;

   // One restoring step; quotient bits come out most significant first
   assign shifted = PROD_W'(span_ff) << bit_ff;
   assign ge      = rem_ff >= shifted;
   assign rem_in  = ge ? rem_ff - shifted : rem_ff;
   assign quot_in = {quot_ff[VOLT_W-2:0], ge};

   always_comb begin
      volts_in = volts_ff;
      if (cmd.load) begin
         if (req_adc_sample <= ADC_POINTS[0])
            volts_in = VOLT_POINTS[0];
         else
            volts_in = VOLT_POINTS[TABLE_POINTS-1];
      end else if (cmd.div && status.div_last) begin
         if (span_ff == '0) volts_in = VOLT_POINTS[k_ff];
         else               volts_in = VOLT_POINTS[k_ff] + quot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         raw_ff     <= req_adc_sample;
         clamped_ff <= (req_adc_sample <= ADC_POINTS[0]) ||
                       (req_adc_sample >= ADC_POINTS[TABLE_POINTS-1]);
         k_ff       <= '0;
      end else if (cmd.step) begin
         k_ff <= kn;
      end
      if (cmd.mult) begin
         rem_ff  <= (raw_ff - ADC_POINTS[k_ff]) * (VOLT_POINTS[kn] - VOLT_POINTS[k_ff]);
         span_ff <= ADC_POINTS[kn] - ADC_POINTS[k_ff];
         quot_ff <= '0;
         bit_ff  <= STEP_W'(DIV_STEPS - 1);
      end else if (cmd.div) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         bit_ff  <= bit_ff - STEP_W'(1);
      end
      volts_ff <= volts_in;
   end

   // Running sum of the ring: drop the oldest entry, add the new one
   assign sum_in = sum_ff - SUM_W'(hist_ff[ptr_ff]) + SUM_W'(volts_ff);
   assign avg    = sum_in[SUM_W-1:AVG_SHIFT];

   assign ov_hit    = volts_ff >= ov_limit_ff;
   assign uv_hit    = uv_en_ff && (volts_ff <= uv_limit_ff);
   assign in_window = (avg > pc_low_ff) && (avg < pc_high_ff);

   always_comb begin
      over_in  = over_ff | ov_hit;
      under_in = under_ff | uv_hit;
      relay_in = relay_ff && !ov_hit && !uv_hit;
      ready_in = ready_ff;
      cnt_in   = cnt_ff;
      if (in_window) begin
         if (cnt_ff < settle_ff) begin
            cnt_in   = cnt_ff + CNT_W'(1);
            ready_in = 1'b0;
         end else begin
            ready_in = 1'b1;
            relay_in = 1'b1;
         end
      end else if (volts_ff < pc_rel_ff) begin
         ready_in = 1'b0;
         cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AVG_DEPTH; i++) hist_ff[i] <= '0;
         ptr_ff   <= '0;
         sum_ff   <= '0;
         cnt_ff   <= '0;
         over_ff  <= 1'b0;
         under_ff <= 1'b0;
         ready_ff <= 1'b0;
         relay_ff <= 1'b0;
      end else if (cmd.commit) begin
         hist_ff[ptr_ff] <= volts_ff;
         ptr_ff   <= ptr_ff + AVG_SHIFT'(1);
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
         over_ff  <= over_in;
         under_ff <= under_in;
         ready_ff <= ready_in;
         relay_ff <= relay_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_bus_volt        <= volts_ff;
         rsp_bus_volt_avg    <= avg;
         rsp_over_volt       <= over_in;
         rsp_under_volt      <= under_in;
         rsp_precharge_ready <= ready_in;
         rsp_relay_closed    <= relay_in;
         rsp_pwm_shutdown    <= ov_hit | uv_hit;
      end
   end

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_limit_ff <= RST_OVERVOLT_LIMIT;
         uv_limit_ff <= RST_UNDERVOLT_LIMIT;
         uv_en_ff    <= RST_UNDERVOLT_ENABLE;
         pc_low_ff   <= RST_PRECHARGE_LOW;
         pc_high_ff  <= RST_PRECHARGE_HIGH;
         pc_rel_ff   <= RST_PRECHARGE_RELEASE;
         settle_ff   <= RST_SETTLE_COUNT;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_OVERVOLT_LIMIT:    ov_limit_ff <= csr_wdata[VOLT_W-1:0];
            CSR_UNDERVOLT_LIMIT:   uv_limit_ff <= csr_wdata[VOLT_W-1:0];
            CSR_UNDERVOLT_ENABLE:  uv_en_ff    <= csr_wdata[0];
            CSR_PRECHARGE_LOW:     pc_low_ff   <= csr_wdata[VOLT_W-1:0];
            CSR_PRECHARGE_HIGH:    pc_high_ff  <= csr_wdata[VOLT_W-1:0];
            CSR_PRECHARGE_RELEASE: pc_rel_ff   <= csr_wdata[VOLT_W-1:0];
            CSR_SETTLE_COUNT:      settle_ff   <= csr_wdata[CNT_W-1:0];
            default:               ;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> rtl/bvm_checker.sv
// ----------------------------------------------------------------------------
// bvm_checker
// Port-level checks for the bus voltage monitor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bvm_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic [bvm_pkg::VOLT_W-1:0]    rsp_bus_volt,
   input wire logic [bvm_pkg::VOLT_W-1:0]    rsp_bus_volt_avg,
   input wire logic                          rsp_over_volt,
   input wire logic                          rsp_under_volt,
   input wire logic                          rsp_pwm_shutdown
);
   import bvm_pkg::*;

   // converted volts stay inside the table range
   a_volt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bus_volt >= VOLT_POINTS[0]) &&
                    (rsp_bus_volt <= VOLT_POINTS[TABLE_POINTS-1]))
      else $error("bus_volt out of table range");

   // mean of the ring cannot exceed the top table value
   a_avg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bus_volt_avg <= VOLT_POINTS[TABLE_POINTS-1])
      else $error("bus_volt_avg out of range");

   // a shutdown always comes with a latched fault flag
   a_shutdown_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pwm_shutdown |-> rsp_over_volt || rsp_under_volt)
      else $error("pwm_shutdown without fault flag");

   // one item in flight: no accept in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

endmodule

bind bus_voltage_monitor_precharge bvm_checker u_bvm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_bus_volt     (rsp_bus_volt),
   .rsp_bus_volt_avg (rsp_bus_volt_avg),
   .rsp_over_volt    (rsp_over_volt),
   .rsp_under_volt   (rsp_under_volt),
   .rsp_pwm_shutdown (rsp_pwm_shutdown)
);

`default_nettype wire
